FILE: src/mlfd_pkg.sv
// shared types and constants for the magic-length frame deframer
`default_nettype none
package mlfd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  // register indexes on the configuration port (byte address / 4)
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_LEN     = 2'd2;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
  localparam logic [15:0] MAX_LEN_RST     = 16'd252;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_REJECT  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DISCARD = 3'd5
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic [15:0] length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } res_word_t;

endpackage
`default_nettype wire

FILE: src/mlfd_front.sv
// front end: sync hunt, header parse and classification of each received byte
`default_nettype none
module mlfd_front
  import mlfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [7:0]  sync_first,
  input  wire logic [7:0]  sync_second,
  input  wire logic [15:0] max_len,
  output res_word_t        word
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] hlen_r, hlen_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      hlen_r  <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hlen_r  <= hlen_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  logic [15:0] len_full;
  logic [16:0] cnt_inc;

  assign len_full = {hlen_r[15:8], rx_byte};
  assign cnt_inc  = {1'b0, cnt_r} + 17'd1;

  always_comb begin
    phase_nxt       = PH_SYNC1;
    hlen_nxt        = hlen_r;
    cnt_nxt         = cnt_r;
    word.valid      = 1'b0;
    word.res.kind   = KIND_PAYLOAD;
    word.res.data   = 8'd0;
    word.res.index  = 16'd0;
    word.res.length = hlen_r;
    word.res.last   = 1'b0;
    unique case (phase_r)
      PH_SYNC1: begin
        phase_nxt = (rx_byte == sync_first) ? PH_SYNC2 : PH_SYNC1;
      end
      PH_SYNC2: begin
        // a mismatch is dropped, not retried as a first sync byte
        phase_nxt = (rx_byte == sync_second) ? PH_LEN_HI : PH_SYNC1;
      end
      PH_LEN_HI: begin
        hlen_nxt  = {rx_byte, 8'd0};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        hlen_nxt = len_full;
        cnt_nxt  = 16'd0;
        if (len_full == 16'd0) begin
          phase_nxt = PH_DISCARD;
        end else if (len_full > max_len) begin
          phase_nxt       = PH_SYNC1;
          word.valid      = accept;
          word.res.kind   = KIND_REJECT;
          word.res.length = len_full;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        cnt_nxt        = cnt_inc[15:0];
        word.valid     = accept;
        word.res.data  = rx_byte;
        word.res.index = cnt_r;
        word.res.last  = cnt_inc >= {1'b0, hlen_r};
        phase_nxt      = word.res.last ? PH_SYNC1 : PH_PAYLOAD;
      end
      PH_DISCARD: begin
        phase_nxt = PH_SYNC1;
      end
      default: begin
        phase_nxt = (rx_byte == sync_first) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/mlfd_queue.sv
// short queue of result words between front and back
`default_nettype none
module mlfd_queue
  import mlfd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire res_word_t wr_word,
  output logic           full,
  input  wire logic      rd_take,
  output res_word_t      rd_word
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  result_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full          = (cnt_r == CNT_FULL);
  assign do_wr         = wr_word.valid && !full;
  assign do_rd         = rd_take && (cnt_r != '0);
  assign rd_word.valid = (cnt_r != '0);
  assign rd_word.res   = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wp_r <= (wp_r == PTR_LAST) ? '0 : wp_r + PTR_W'(1);
      end
      if (do_rd) begin
        rp_r <= (rp_r == PTR_LAST) ? '0 : rp_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_word.res;
    end
  end

endmodule
`default_nettype wire

FILE: src/mlfd_back.sv
// back end: output register that drains the queue and presents one result word
`default_nettype none
module mlfd_back
  import mlfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire res_word_t q_word,
  output logic           q_take,
  input  wire logic      pop,
  output logic           empty,
  output result_t        res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // refill whenever the output slot is free or being taken this cycle
  assign q_take    = q_word.valid && (!valid_r || pop);
  assign valid_nxt = q_take || (valid_r && !pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      res_r <= q_word.res;
    end
  end

  assign empty = !valid_r;
  assign res   = res_r;

endmodule
`default_nettype wire

FILE: src/magic_length_frame_deframer.sv
// top level of the sync-word, length-prefixed frame deframer
//
// Input: one received byte per word on in_rx_byte, taken when push is high
// and full is low. The parser hunts for the two sync bytes, reads a
// big-endian 16-bit length and streams the payload out byte by byte.
// Output: empty low means a result word is on the out_ ports; pop takes it.
// Each payload byte yields one word with its index, the frame length and a
// last flag; a length above the maximum yields one reject word.
// Throughput is one byte per cycle while full is low. A result reaches
// the outputs through the queue write and then the output register.
// When pop stays low the results fill the output register and the queue
// behind it; full rises once the queue holds QDEPTH words and bytes then
// wait at the input. Bytes that give no result are only held off while
// full is high.
// Reset (rst_n low, synchronous) returns the parser to hunting, empties
// the queue and loads the register defaults 0xAA, 0x55 and 252.
// Registers sit on the APB port at byte addresses 0, 4 and 8 and must be
// written only while the block is idle; the block does not enforce this.
`default_nettype none
module magic_length_frame_deframer
  import mlfd_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            in_rx_byte,
  output logic                       empty,
  input  wire logic                  pop,
  output logic                       out_result_kind,
  output logic [7:0]                 out_payload_byte,
  output logic [15:0]                out_payload_index,
  output logic [15:0]                out_frame_length,
  output logic                       out_last_of_frame,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [7:0]  sync_first_r, sync_second_r;
  logic [15:0] max_len_r;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      max_len_r     <= MAX_LEN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SYNC_FIRST:  sync_first_r  <= pwdata[7:0];
        REG_SYNC_SECOND: sync_second_r <= pwdata[7:0];
        REG_MAX_LEN:     max_len_r     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SYNC_FIRST:  prdata = {24'd0, sync_first_r};
      REG_SYNC_SECOND: prdata = {24'd0, sync_second_r};
      REG_MAX_LEN:     prdata = {16'd0, max_len_r};
      default:         prdata = '0;
    endcase
  end

  res_word_t front_word, q_word;
  logic      q_full, q_take, accept;
  result_t   res;

  assign full   = q_full;
  assign accept = push && !q_full;

  mlfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .rx_byte     (in_rx_byte),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .max_len     (max_len_r),
    .word        (front_word)
  );

  mlfd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_word (front_word),
    .full    (q_full),
    .rd_take (q_take),
    .rd_word (q_word)
  );

  mlfd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_word (q_word),
    .q_take (q_take),
    .pop    (pop),
    .empty  (empty),
    .res    (res)
  );

  assign out_result_kind   = res.kind;
  assign out_payload_byte  = res.data;
  assign out_payload_index = res.index;
  assign out_frame_length  = res.length;
  assign out_last_of_frame = res.last;

endmodule
`default_nettype wire

FILE: bench/magic_length_frame_deframer_tb.sv
// self-checking bench for the magic-length frame deframer
module magic_length_frame_deframer_tb;
  import mlfd_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 300000;

  // expected output words, worked out from the bytes the block accepted
  class deframe_scoreboard;
    logic [7:0]  sync_a;
    logic [7:0]  sync_b;
    logic [15:0] len_limit;
    phase_t      phase;
    logic [15:0] hdr_len;
    logic [15:0] rx_count;
    result_t     pending[$];
    int          errors;

    function new();
      sync_a    = SYNC_FIRST_RST;
      sync_b    = SYNC_SECOND_RST;
      len_limit = MAX_LEN_RST;
      phase     = PH_SYNC1;
      hdr_len   = '0;
      rx_count  = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_SYNC_FIRST:  sync_a = value[7:0];
        REG_SYNC_SECOND: sync_b = value[7:0];
        REG_MAX_LEN:     len_limit = value[15:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      result_t r;
      logic    last;
      case (phase)
        PH_SYNC2: phase = (b == sync_b) ? PH_LEN_HI : PH_SYNC1;
        PH_LEN_HI: begin
          hdr_len = {b, 8'h00};
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          hdr_len = {hdr_len[15:8], b};
          rx_count = '0;
          if (hdr_len == 16'd0) begin
            phase = PH_DISCARD;
          end else if (hdr_len > len_limit) begin
            phase = PH_SYNC1;
            r = '{kind: KIND_REJECT, data: 8'h00, index: 16'd0, length: hdr_len, last: 1'b0};
            pending.push_back(r);
          end else begin
            phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          last = ({1'b0, rx_count} + 17'd1) >= {1'b0, hdr_len};
          r = '{kind: KIND_PAYLOAD, data: b, index: rx_count, length: hdr_len, last: last};
          pending.push_back(r);
          rx_count = rx_count + 16'd1;
          if (last) phase = PH_SYNC1;
        end
        PH_DISCARD: phase = PH_SYNC1;
        // hunting, and any code that should never be seen
        default: phase = (b == sync_a) ? PH_SYNC2 : PH_SYNC1;
      endcase
    endfunction

    function string show(result_t r);
      return $sformatf("kind %0d byte %02h index %0d length %0d last %0d",
                       r.kind, r.data, r.index, r.length, r.last);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: %s", show(got));
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind || got.data !== want.data || got.index !== want.index ||
          got.length !== want.length || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("word mismatch");
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  pop = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  wire                   full;
  wire                   empty;
  wire                   out_result_kind;
  wire  [7:0]            out_payload_byte;
  wire  [15:0]           out_payload_index;
  wire  [15:0]           out_frame_length;
  wire                   out_last_of_frame;
  wire  [CFG_DATA_W-1:0] prdata;
  wire                   pready;

  deframe_scoreboard sb;
  bit                gaps_on = 1'b1;
  int                frame_bytes = 0;
  int                cycle_count = 0;

  magic_length_frame_deframer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_rx_byte        (in_rx_byte),
    .empty             (empty),
    .pop               (pop),
    .out_result_kind   (out_result_kind),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_frame_length  (out_frame_length),
    .out_last_of_frame (out_last_of_frame),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("magic_length_frame_deframer_tb: done, errors");
      $finish;
    end
  end

  // result side: take words, stall now and then
  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      sb.check_word('{kind: kind_t'(out_result_kind), data: out_payload_byte,
                      index: out_payload_index, length: out_frame_length,
                      last: out_last_of_frame});
    pop <= !gaps_on || ($urandom_range(0, 99) >= 10);
  end

  task automatic send_byte(logic [7:0] b);
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      push <= 1'b0;
      in_rx_byte <= 8'($urandom);
      @(posedge clk);
    end
    push <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (full);
    sb.note_byte(b);
  endtask

  // header from the current sync values; payload only when the length is taken, one dropped byte after a zero length
  task automatic send_frame(logic [15:0] len);
    int n;
    send_byte(sb.sync_a);
    send_byte(sb.sync_b);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    n = 4;
    if (len == 16'd0) begin
      send_byte(8'($urandom));
      n++;
    end else if (len <= sb.len_limit) begin
      for (int i = 0; i < len; i++) send_byte(8'($urandom));
      n += len;
    end
    frame_bytes += n;
  endtask

  function automatic logic [15:0] pick_length(int limit);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 16'd0;
    if (r < 16 && limit < 65535) return 16'($urandom_range(limit + 1, 65535));
    if (r < 22 && limit > 0 && limit <= 64) return 16'(limit);
    return 16'($urandom_range(1, (limit > 0 && limit < 24) ? limit : 24));
  endfunction

  task automatic run_random(int quota);
    int r;
    int start;
    start = frame_bytes;
    while (frame_bytes - start < quota) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_frame(pick_length(int'(sb.len_limit)));
      end else if (r < 85) begin
        // first sync byte then a wrong second one
        send_byte(sb.sync_a);
        send_byte(sb.sync_b ^ 8'($urandom_range(1, 255)));
      end else if (r < 92) begin
        // header cut short; the next bytes become its low length byte onward
        send_byte(sb.sync_a);
        send_byte(sb.sync_b);
        send_byte(8'h00);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
    end
  endtask

  // input quiet, every expected word out, then room for bytes still in flight
  task automatic settle();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
  endtask

  task automatic set_config(logic [7:0] first, logic [7:0] second, logic [15:0] limit);
    cfg_write(REG_SYNC_FIRST, {24'h0, first});
    cfg_write(REG_SYNC_SECOND, {24'h0, second});
    cfg_write(REG_MAX_LEN, {16'h0, limit});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [7:0] opening[$];
    sb = new();
    opening = '{
      // one-byte frame
      8'hAA, 8'h55, 8'h00, 8'h01, 8'hFF,
      // zero length: the byte after it is dropped even though it looks like sync
      8'hAA, 8'h55, 8'h00, 8'h00, 8'hAA,
      // bad second sync byte that equals the first is not rescanned
      8'hAA, 8'hAA, 8'h55,
      // longest possible header, rejected
      8'hAA, 8'h55, 8'hFF, 8'hFF,
      // just above the default maximum
      8'hAA, 8'h55, 8'h00, 8'hFD,
      // two-byte frame with extreme payload values
      8'hAA, 8'h55, 8'h00, 8'h02, 8'h00, 8'hFF
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[i]) send_byte(opening[i]);
    run_random(250);

    settle();
    set_config(8'h00, 8'hFF, 16'd1);
    run_random(150);

    // long stretch with no gaps on either side
    settle();
    set_config(8'hFF, 8'h00, 16'hFFFF);
    gaps_on = 1'b0;
    send_frame(16'd300);
    run_random(100);

    // a zero maximum rejects every nonzero length; index 3 holds no register
    settle();
    gaps_on = 1'b1;
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    set_config(8'h3C, 8'h3C, 16'd0);
    run_random(100);

    settle();
    set_config(8'($urandom), 8'($urandom), 16'($urandom_range(1, 40)));
    run_random(200);

    settle();
    set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_LEN_RST);
    run_random(150);

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("magic_length_frame_deframer_tb: done, clean");
    end else begin
      $display("magic_length_frame_deframer_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/mlfd_pkg.sv
src/mlfd_front.sv
src/mlfd_queue.sv
src/mlfd_back.sv
src/magic_length_frame_deframer.sv
bench/magic_length_frame_deframer_tb.sv
